### hw/rtl/sli_pkg.sv
// shared types and constants for the sorted list intersection block
package sli_pkg;

    localparam int LIST_DEPTH_DEFAULT = 1024;
    localparam int ID_BITS_DEFAULT    = 32;
    localparam int DOC_ID_BITS        = 32;
    localparam int COUNT_BITS         = 11;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_PROBE  = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [DOC_ID_BITS-1:0] doc_id;
    } in_item_t;

    typedef struct packed {
        logic [DOC_ID_BITS-1:0] match_id;
        logic                   is_summary;
        logic [COUNT_BITS-1:0]  result_count;
        logic                   overflowed;
    } out_item_t;

endpackage

### hw/rtl/sli_store.sv
// list store: one write port, one read port with registered read data
module sli_store #(
    parameter int DEPTH = sli_pkg::LIST_DEPTH_DEFAULT,
    parameter int WIDTH = sli_pkg::DOC_ID_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sli_ctrl.sv
// request sequencer: pointers, probe walk over the store, result register
module sli_ctrl #(
    parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEFAULT,
    parameter int ID_BITS    = sli_pkg::ID_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sli_pkg::in_item_t             request,
    output logic                          busy,
    output logic                          result_valid,
    output sli_pkg::out_item_t            result,
    output logic                          mem_wr_en,
    output logic [$clog2(LIST_DEPTH)-1:0] mem_wr_addr,
    output logic [((ID_BITS < sli_pkg::DOC_ID_BITS) ? ID_BITS
                   : sli_pkg::DOC_ID_BITS)-1:0] mem_wr_data,
    output logic                          mem_rd_en,
    output logic [$clog2(LIST_DEPTH)-1:0] mem_rd_addr,
    input  logic [((ID_BITS < sli_pkg::DOC_ID_BITS) ? ID_BITS
                   : sli_pkg::DOC_ID_BITS)-1:0] mem_rd_data
);

    import sli_pkg::*;

    localparam int W  = (ID_BITS < DOC_ID_BITS) ? ID_BITS : DOC_ID_BITS;
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int XW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    state_t          state_reg, state_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [CW-1:0]   rp_reg, rp_next;
    logic [CW-1:0]   wp_reg, wp_next;
    logic            ovf_reg, ovf_next;
    logic [W-1:0]    id_reg, id_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_reg, out_next;

    logic            accept;
    kind_t           kind;
    logic [W-1:0]    req_id;
    logic [CW-1:0]   rp_inc;
    logic            more;
    logic            lt;
    logic            eq;
    logic [XW-1:0]   wp_ext;

    assign accept = start && (state_reg == ST_IDLE);
    assign kind   = kind_t'(request.kind);
    assign req_id = request.doc_id[W-1:0];
    assign rp_inc = rp_reg + CW'(1);
    assign more   = rp_inc < len_reg;
    assign lt     = mem_rd_data < id_reg;
    assign eq     = mem_rd_data == id_reg;
    assign wp_ext = XW'(wp_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_PROBE && rp_reg < len_reg)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!(lt && more))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store access
    always_comb
    begin
        len_next       = len_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        ovf_next       = ovf_reg;
        id_next        = id_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = len_reg[AW-1:0];
        mem_wr_data    = req_id;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = rp_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_CLEAR:
                        begin
                            len_next = '0;
                            rp_next  = '0;
                            wp_next  = '0;
                            ovf_next = 1'b0;
                        end
                        KIND_APPEND:
                        begin
                            if (len_reg < DEPTH_C)
                            begin
                                mem_wr_en = 1'b1;
                                len_next  = len_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_PROBE:
                        begin
                            id_next   = req_id;
                            mem_rd_en = rp_reg < len_reg;
                        end
                        KIND_FINISH:
                        begin
                            len_next                = wp_reg;
                            rp_next                 = '0;
                            wp_next                 = '0;
                            out_valid_next          = 1'b1;
                            out_next.match_id       = '0;
                            out_next.is_summary     = 1'b1;
                            out_next.result_count   = wp_ext[COUNT_BITS-1:0];
                            out_next.overflowed     = ovf_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (lt)
                begin
                    rp_next     = rp_inc;
                    mem_rd_en   = more;
                    mem_rd_addr = rp_inc[AW-1:0];
                end
                else if (eq)
                begin
                    // compact the match into list a
                    mem_wr_en             = 1'b1;
                    mem_wr_addr           = wp_reg[AW-1:0];
                    mem_wr_data           = id_reg;
                    wp_next               = wp_reg + CW'(1);
                    rp_next               = rp_inc;
                    out_valid_next        = 1'b1;
                    out_next.match_id     = DOC_ID_BITS'(id_reg);
                    out_next.is_summary   = 1'b0;
                    out_next.result_count = '0;
                    out_next.overflowed   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        out_reg <= out_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### hw/rtl/sorted_list_intersection_top.sv
// top level of the sorted list intersection block
//
// requests enter on start/request and are taken at a clock edge with start
// high and busy low. kinds: clear list a, append an id to a, probe with the
// next id of list b, finish b. list a lives in a one-port-read, one-port-write
// store with registered read data.
// clear, append and finish never raise busy. finish puts
// its summary on result in the cycle after the request is taken.
// a probe walks list a from the read pointer, one store entry per cycle,
// unless the pointer is already at the end of a, in which case no walk starts;
// the entries compared are the skipped ids plus the final one.
// a match appears on result with result_valid in the cycle after the last
// compare, while busy drops.
// result_valid is high for exactly one cycle per result; there is no stall
// from the receiver, so results must be taken when shown.
// reset clears the pointers, list length and overflow flag; list a is empty
// after reset and no clearing pass is needed.
module sorted_list_intersection_top #(
    parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEFAULT,
    parameter int ID_BITS    = sli_pkg::ID_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sli_pkg::in_item_t  request,
    output logic               busy,
    output logic               result_valid,
    output sli_pkg::out_item_t result
);

    import sli_pkg::*;

    localparam int W  = (ID_BITS < DOC_ID_BITS) ? ID_BITS : DOC_ID_BITS;
    localparam int AW = $clog2(LIST_DEPTH);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [W-1:0]  mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [W-1:0]  mem_rd_data;

    sli_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    sli_store #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // a summary only follows an accepted finish
    a_summary_after_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_summary) |->
            $past(start && !busy && request.kind == KIND_FINISH)
    ) else $error("summary without finish request");

    // a match only comes out of a probe walk
    a_match_after_walk: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result.is_summary) |-> $past(busy)
    ) else $error("match result without probe walk");

    // the store is never read and written in the same cycle
    a_no_rw_overlap: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en)
    ) else $error("store read and write overlap");

    // a walk that ends raises no new read
    a_walk_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (busy && !mem_rd_en) |=> !busy
    ) else $error("walk continued without a read");

endmodule
